>>> rtl/wsf_pkg.sv
// Shared constants and handshake types for the window feature extractor.
package wsf_pkg;

  localparam int WINDOW_MAX = 1024;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int SUM_W      = SAMPLE_W + CNT_W;
  localparam int SQ_W       = PROD_W + CNT_W - 2;
  localparam int STEP_W     = SAMPLE_W + 1 + CNT_W - 1;
  localparam int SQSTEP_W   = PROD_W + CNT_W;
  localparam int PASS_W     = SAMPLE_W + CNT_W + 1;
  localparam int DIV_W      = SQSTEP_W + 8;
  localparam int DIVISOR_W  = CNT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/wsf_sample_ram.sv
// Sample store: one write port, one read port with registered read data.
module wsf_sample_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [wsf_pkg::ADDR_W-1:0]   waddr,
  input  logic [wsf_pkg::SAMPLE_W-1:0] wdata,
  input  logic [wsf_pkg::ADDR_W-1:0]   raddr,
  output logic [wsf_pkg::SAMPLE_W-1:0] rdata
);
  import wsf_pkg::*;

  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/wsf_divider.sv
// Restoring divider, one quotient bit per cycle, shared by all the averages.
module wsf_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  wsf_pkg::div_req_t req,
  output wsf_pkg::div_rsp_t rsp
);
  import wsf_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> rtl/window_signal_features.sv
// Window feature extractor: load pass, above-mean pass, averages, result register.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_sample_value, in_end_of_window
//   out     | output    | out_valid, out_stall, out_* result fields
//
// Loading takes one sample per cycle (three-stage pipe: register, update, accumulate).
// After the marked sample the load pipe drains, then the above-mean pass runs (one store read
// per cycle), then the divisions run one after another on the shared serial divider
// (one division for n < 2, four otherwise). Input is stalled from the marked sample
// until its result is moved to the output register.
// Synchronous active-low reset clears all control state; the store is not cleared.
// The output register holds a result while out_stall is high; the next window loads meanwhile.
module window_signal_features (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_sample_value,
  input  logic        in_end_of_window,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [40:0] out_sum_of_squares,
  output logic [15:0] out_above_avg_fraction,
  output logic [9:0]  out_peak_first_index,
  output logic [9:0]  out_peak_last_index,
  output logic signed [24:0] out_avg_step,
  output logic [23:0] out_avg_abs_step,
  output logic [39:0] out_avg_sq_step,
  output logic [10:0] out_window_len,
  output logic        out_window_overflow
);
  import wsf_pkg::*;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_FLUSH = 3'd1;
  localparam logic [2:0] ST_PASS  = 3'd2;
  localparam logic [2:0] ST_DIVGO = 3'd3;
  localparam logic [2:0] ST_DIVWT = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [1:0] SEL_FRAC = 2'd0;
  localparam logic [1:0] SEL_STEP = 2'd1;
  localparam logic [1:0] SEL_ABS  = 2'd2;
  localparam logic [1:0] SEL_SQ   = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [1:0] sel_r;

  // load pipeline
  logic                       in_xfer;
  logic                       v_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       pv_r;
  logic [PROD_W-1:0]          sq_prod_r;
  logic                       dv_r;
  logic [PROD_W-1:0]          sqd_prod_r;

  // window state
  logic [CNT_W-1:0]           count_r;
  logic [SQ_W-1:0]            sq_acc_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] peak_r;
  logic [ADDR_W-1:0]          pfirst_r;
  logic [ADDR_W-1:0]          plast_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [STEP_W-1:0]   step_r;
  logic [STEP_W-1:0]          abs_r;
  logic [SQSTEP_W-1:0]        sqstep_r;
  logic [CNT_W-1:0]           above_r;
  logic                       ovf_r;

  logic                       kept;
  logic signed [SAMPLE_W:0]   d;
  logic [SAMPLE_W-1:0]        ad;
  logic signed [PROD_W-1:0]   xsq;

  // above-mean pass
  logic [CNT_W-1:0]           issue_r;
  logic                       rv1_r;
  logic                       rv2_r;
  logic signed [PASS_W-1:0]   pprod_r;
  logic signed [PASS_W-1:0]   pprod;
  logic [SAMPLE_W-1:0]        rdata;
  logic                       pass_done;

  // divider
  div_req_t                   dreq;
  div_rsp_t                   drsp;
  logic [STEP_W-1:0]          step_mag;
  logic [CNT_W-1:0]           m_len;
  logic [15:0]                frac_r;
  logic [24:0]                avg_step_r;
  logic [23:0]                avg_abs_r;
  logic [39:0]                avg_sq_r;
  logic                       short_win;
  logic                       out_load;

  assign in_stall = (state_r != ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;

  assign kept = (count_r < CNT_W'(WINDOW_MAX));
  assign d    = {x_r[SAMPLE_W-1], x_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign ad   = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
  assign xsq  = x_r * x_r;

  assign pprod     = $signed(rdata) * $signed({1'b0, count_r});
  assign pass_done = (issue_r == count_r) && !rv1_r && !rv2_r;

  assign m_len     = count_r - 1'b1;
  assign short_win = (count_r < CNT_W'(2));
  assign step_mag  = step_r[STEP_W-1] ? STEP_W'(-step_r) : STEP_W'(step_r);
  assign out_load  = (state_r == ST_OUT) && (!out_valid || !out_stall);

  wsf_sample_ram u_ram (
    .clk   (clk),
    .we    (v_r && kept),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (x_r),
    .raddr (issue_r[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    dreq.start   = (state_r == ST_DIVGO);
    dreq.divisor = m_len;
    unique case (sel_r)
      SEL_FRAC: begin
        dreq.dividend = DIV_W'({above_r, 16'd0});
        dreq.divisor  = count_r;
      end
      SEL_STEP: dreq.dividend = DIV_W'({step_mag, 8'd0});
      SEL_ABS:  dreq.dividend = DIV_W'({abs_r, 8'd0});
      SEL_SQ:   dreq.dividend = DIV_W'({sqstep_r, 8'd0});
      default:  dreq.dividend = '0;
    endcase
  end

  wsf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_xfer && in_end_of_window) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!v_r && !pv_r && !dv_r) state_nxt = ST_PASS;
      ST_PASS:  if (pass_done) state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIVWT;
      ST_DIVWT: begin
        if (drsp.done) begin
          if (sel_r == SEL_SQ || (sel_r == SEL_FRAC && short_win)) state_nxt = ST_OUT;
          else state_nxt = ST_DIVGO;
        end
      end
      ST_OUT:   if (out_load) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      sel_r    <= SEL_FRAC;
      v_r      <= 1'b0;
      pv_r     <= 1'b0;
      dv_r     <= 1'b0;
      rv1_r    <= 1'b0;
      rv2_r    <= 1'b0;
      issue_r  <= '0;
      count_r  <= '0;
      sq_acc_r <= '0;
      sum_r    <= '0;
      peak_r   <= '0;
      pfirst_r <= '0;
      plast_r  <= '0;
      prev_r   <= '0;
      step_r   <= '0;
      abs_r    <= '0;
      sqstep_r <= '0;
      above_r  <= '0;
      ovf_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // stage 1: capture the sample
      v_r <= in_xfer;
      if (in_xfer) begin
        x_r <= in_sample_value;
      end

      // stage 2: update running state, form products
      pv_r <= v_r && kept;
      dv_r <= v_r && kept && (count_r != '0);
      if (v_r) begin
        if (kept) begin
          sq_prod_r <= PROD_W'(xsq);
          sum_r     <= sum_r + SUM_W'(x_r);
          if (count_r == '0) begin
            peak_r   <= x_r;
            pfirst_r <= '0;
            plast_r  <= '0;
          end else begin
            if (x_r > peak_r) begin
              peak_r   <= x_r;
              pfirst_r <= count_r[ADDR_W-1:0];
              plast_r  <= count_r[ADDR_W-1:0];
            end else if (x_r == peak_r) begin
              plast_r <= count_r[ADDR_W-1:0];
            end
            step_r     <= step_r + STEP_W'(d);
            abs_r      <= abs_r + STEP_W'(ad);
            sqd_prod_r <= ad * ad;
          end
          prev_r  <= x_r;
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end

      // stage 3: wide accumulation
      if (pv_r) sq_acc_r <= sq_acc_r + SQ_W'(sq_prod_r);
      if (dv_r) sqstep_r <= sqstep_r + SQSTEP_W'(sqd_prod_r);

      // above-mean pass: read, multiply, compare
      if (state_r == ST_PASS && issue_r != count_r) begin
        issue_r <= issue_r + 1'b1;
        rv1_r   <= 1'b1;
      end else begin
        rv1_r <= 1'b0;
      end
      rv2_r <= rv1_r;
      if (rv1_r) pprod_r <= pprod;
      if (rv2_r && (pprod_r > PASS_W'(sum_r))) above_r <= above_r + 1'b1;

      if (state_r == ST_DIVWT && drsp.done) begin
        sel_r <= sel_r + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        sel_r     <= SEL_FRAC;
        issue_r   <= '0;
        count_r   <= '0;
        sq_acc_r  <= '0;
        sum_r     <= '0;
        peak_r    <= '0;
        pfirst_r  <= '0;
        plast_r   <= '0;
        prev_r    <= '0;
        step_r    <= '0;
        abs_r     <= '0;
        sqstep_r  <= '0;
        above_r   <= '0;
        ovf_r     <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // division results
  always_ff @(posedge clk) begin
    if (state_r == ST_DIVGO && sel_r == SEL_FRAC) begin
      avg_step_r <= '0;
      avg_abs_r  <= '0;
      avg_sq_r   <= '0;
    end
    if (state_r == ST_DIVWT && drsp.done) begin
      case (sel_r)
        SEL_FRAC: frac_r <= (drsp.quotient > DIV_W'(65535)) ? 16'hFFFF : drsp.quotient[15:0];
        SEL_STEP: avg_step_r <= step_r[STEP_W-1] ? 25'(-drsp.quotient[24:0])
                                                 : drsp.quotient[24:0];
        SEL_ABS:  avg_abs_r <= drsp.quotient[23:0];
        default:  avg_sq_r <= drsp.quotient[39:0];
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_of_squares     <= sq_acc_r;
      out_above_avg_fraction <= frac_r;
      out_peak_first_index   <= pfirst_r;
      out_peak_last_index    <= plast_r;
      out_avg_step           <= $signed(avg_step_r);
      out_avg_abs_step       <= avg_abs_r;
      out_avg_sq_step        <= avg_sq_r;
      out_window_len         <= count_r;
      out_window_overflow    <= ovf_r;
    end
  end

endmodule

>>> dv/window_checker.sv
// Checker for window_signal_features: watches both channels, predicts results, compares.
module window_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample_value,
  input  logic               in_end_of_window,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [40:0]        out_sum_of_squares,
  input  logic [15:0]        out_above_avg_fraction,
  input  logic [9:0]         out_peak_first_index,
  input  logic [9:0]         out_peak_last_index,
  input  logic signed [24:0] out_avg_step,
  input  logic [23:0]        out_avg_abs_step,
  input  logic [39:0]        out_avg_sq_step,
  input  logic [10:0]        out_window_len,
  input  logic               out_window_overflow,
  output int                 mismatches,
  output int                 pending
);
  import wsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [40:0] energy;
    logic [15:0] frac;
    logic [9:0]  pk_first;
    logic [9:0]  pk_last;
    logic [24:0] step;
    logic [23:0] abs_step;
    logic [39:0] sq_step;
    logic [10:0] len;
    logic        ovf;
  } features_t;

  features_t feature_q[$];

  // shadow window state
  logic signed [15:0] win_mem [WINDOW_MAX];
  longint      n_kept, energy_sum, value_sum, peak_val, first_pos, last_pos, prev_val;
  longint      step_sum;
  longint unsigned abs_sum, sq_sum;
  bit          dropped;

  function automatic longint unsigned scale_div(longint unsigned acc, longint unsigned n);
    return (acc / n) * 256 + ((acc % n) * 256) / n;
  endfunction

  task automatic clear_win();
    n_kept = 0; energy_sum = 0; value_sum = 0; peak_val = 0; first_pos = 0;
    last_pos = 0; prev_val = 0; step_sum = 0; abs_sum = 0; sq_sum = 0; dropped = 0;
  endtask

  task automatic take_sample(logic signed [15:0] s, logic last);
    longint x, d, above;
    longint unsigned ad, q, f;
    features_t r;
    x = s;
    if (n_kept < WINDOW_MAX) begin
      win_mem[n_kept] = s;
      energy_sum += x * x;
      value_sum += x;
      if (n_kept == 0) begin
        peak_val = x; first_pos = 0; last_pos = 0;
      end else begin
        d = x - prev_val;
        ad = (d < 0) ? -d : d;
        if (x > peak_val) begin
          peak_val = x; first_pos = n_kept; last_pos = n_kept;
        end else if (x == peak_val) begin
          last_pos = n_kept;
        end
        step_sum += d;
        abs_sum += ad;
        sq_sum += ad * ad;
      end
      prev_val = x;
      n_kept++;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    above = 0;
    for (int i = 0; i < n_kept; i++)
      if (longint'(win_mem[i]) * n_kept > value_sum) above++;
    r = '0;
    f = (longint'(above) << 16) / n_kept;
    r.frac = (f > 65535) ? 16'hffff : f[15:0];
    if (n_kept >= 2) begin
      q = scale_div((step_sum < 0) ? -step_sum : step_sum, n_kept - 1);
      if (step_sum < 0) q = -q;
      r.step = q[24:0];
      q = scale_div(abs_sum, n_kept - 1);
      r.abs_step = q[23:0];
      q = scale_div(sq_sum, n_kept - 1);
      r.sq_step = q[39:0];
    end
    r.energy = energy_sum[40:0];
    r.pk_first = first_pos[9:0];
    r.pk_last = last_pos[9:0];
    r.len = n_kept[10:0];
    r.ovf = dropped;
    feature_q.push_back(r);
    clear_win();
  endtask

  task automatic cmp(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    clear_win();
  end

  assign pending = feature_q.size();

  always @(posedge clk) begin
    features_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (feature_q.size() == 0) begin
          $error("result transfer with no window pending");
          mismatches++;
        end else begin
          e = feature_q.pop_front();
          cmp("sum_of_squares", e.energy, out_sum_of_squares);
          cmp("above_avg_fraction", e.frac, out_above_avg_fraction);
          cmp("peak_first_index", e.pk_first, out_peak_first_index);
          cmp("peak_last_index", e.pk_last, out_peak_last_index);
          cmp("avg_step", e.step, $unsigned(out_avg_step));
          cmp("avg_abs_step", e.abs_step, out_avg_abs_step);
          cmp("avg_sq_step", e.sq_step, out_avg_sq_step);
          cmp("window_len", e.len, out_window_len);
          cmp("window_overflow", e.ovf, out_window_overflow);
        end
      end
      if (in_valid && !in_stall) take_sample(in_sample_value, in_end_of_window);
    end
  end
endmodule

>>> dv/testbench.sv
// Top of the window_signal_features testbench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] in_sample_value = '0;
  logic               in_end_of_window = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [40:0]        out_sum_of_squares;
  logic [15:0]        out_above_avg_fraction;
  logic [9:0]         out_peak_first_index;
  logic [9:0]         out_peak_last_index;
  logic signed [24:0] out_avg_step;
  logic [23:0]        out_avg_abs_step;
  logic [39:0]        out_avg_sq_step;
  logic [10:0]        out_window_len;
  logic               out_window_overflow;
  int                 mismatches, pending;
  int                 cycles = 0;
  int                 samples_sent = 0, windows_sent = 0;
  bit                 no_idle = 0;

  window_signal_features dut (.*);
  window_checker checker_i (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 11);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic send(logic signed [15:0] s, logic last);
    while (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sample_value <= s;
    in_end_of_window <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (last) windows_sent++;
  endtask

  // mode 0: full range, 1: extremes, 2: few small values (ties), 3: near zero
  function automatic logic signed [15:0] pick(int mode);
    case (mode)
      1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2: return 16'($urandom_range(3) - 1);
      3: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_window(int len, int mode);
    for (int i = 0; i < len; i++) send(pick(mode), i == len - 1);
  endtask

  initial begin
    int len, mode, big_left;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed: one-sample windows at both extremes
    send(16'sh8000, 1);
    send(16'sh7fff, 1);
    // two samples: largest falling step
    send(16'sh7fff, 0); send(16'sh8000, 1);
    // two samples: largest rising step
    send(16'sh8000, 0); send(16'sh7fff, 1);
    // ties at the maximum
    send(16'sd5, 0); send(16'sd9, 0); send(16'sd9, 0); send(-16'sd3, 0);
    send(16'sd9, 1);
    // constant window, nothing above the mean
    send(16'sd0, 0); send(16'sd0, 0); send(16'sd0, 1);
    // negative, zero and positive samples in one window
    send(-16'sd1, 0); send(-16'sd100, 0); send(16'sd0, 0); send(16'sd1, 1);
    big_left = 1;
    while (samples_sent < 1750) begin
      no_idle = (samples_sent > 700 && samples_sent < 1000);
      mode = $urandom_range(3);
      if (big_left > 0 && samples_sent > 400) begin
        // full store, then samples dropped past capacity
        len = 1024 + $urandom_range(1, 8);
        big_left--;
        mode = 0;
      end else if ($urandom_range(9) == 0) begin
        len = $urandom_range(1, 2);
      end else begin
        len = $urandom_range(3, 30);
      end
      send_window(len, mode);
    end
    in_valid <= 0;
    no_idle = 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("sent %0d samples in %0d windows (short, tied, extreme, full and overflowing)",
             samples_sent, windows_sent);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
